/* rtl/core/krc_pkg.sv */
`default_nettype none

package krc_pkg;

    localparam int DEF_CAPACITY       = 8;
    localparam int DEF_MAX_PAYLOAD    = 4096;
    localparam int DEF_IDENTITY_BYTES = 32;

    // Slot indexes cover the largest supported table; counts match the result field.
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        CMD_STORE     = 3'd0,
        CMD_RETRY     = 3'd1,
        CMD_LOOKUP    = 3'd2,
        CMD_ACK       = 3'd3,
        CMD_CLR_SESS  = 3'd4,
        CMD_CLR_ALL   = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_STORED    = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_CONFLICT  = 4'd2,
        ST_INVALID   = 4'd3,
        ST_TOO_LARGE = 4'd4,
        ST_MATCH     = 4'd5,
        ST_NOT_FOUND = 4'd6,
        ST_DONE      = 4'd7,
        ST_FAILED    = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [63:0]      hit_ident;
        logic [31:0]      hit_handle;
        logic [15:0]      hit_len;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             min_seen;
        logic [31:0]      min_seq;
        logic [IDX_W-1:0] min_idx;
        logic [CNT_W-1:0] sess_cnt;
        logic [CNT_W-1:0] valid_cnt;
    } t_carry;

    typedef struct packed {
        logic             wr;
        logic             free_one;
        logic             clr_sess;
        logic             clr_all;
        logic [IDX_W-1:0] idx;
    } t_upd;

endpackage

`default_nettype wire

/* rtl/core/krc_if.sv */
`default_nettype none

interface krc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] session_key;
    logic [63:0] request_key;
    logic [63:0] identity_digest;
    logic [7:0]  identity_len;
    logic [31:0] payload_handle;
    logic [15:0] payload_len;
    logic [15:0] reader_capacity;

    modport source (
        output valid, cmd, session_key, request_key, identity_digest, identity_len,
               payload_handle, payload_len, reader_capacity,
        input  ready
    );
    modport sink (
        input  valid, cmd, session_key, request_key, identity_digest, identity_len,
               payload_handle, payload_len, reader_capacity,
        output ready
    );
endinterface

interface krc_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] found_handle;
    logic [15:0] found_len;
    logic [6:0]  cleared_count;

    modport source (
        output valid, status, found_handle, found_len, cleared_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_handle, found_len, cleared_count,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/krc_cell.sv */
`default_nettype none

module krc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire krc_pkg::t_carry i_carry,
    output krc_pkg::t_carry      o_carry,
    input  wire krc_pkg::t_upd   i_upd,
    input  wire logic [63:0]     i_session,
    input  wire logic [63:0]     i_request,
    input  wire logic [63:0]     i_identity,
    input  wire logic [31:0]     i_handle,
    input  wire logic [15:0]     i_len,
    input  wire logic [31:0]     i_seq
);
    import krc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic        r_valid;
    logic [63:0] r_sess;
    logic [63:0] r_req;
    logic [63:0] r_ident;
    logic [31:0] r_handle;
    logic [15:0] r_len;
    logic [31:0] r_seq;
    t_carry      r_carry;
    t_carry      n_carry;
    logic        w_sess_hit;
    logic        w_match;
    logic        w_free;

    assign w_sess_hit = r_valid && (r_sess == i_session);
    assign w_match    = w_sess_hit && (r_req == i_request);
    assign w_free     = i_upd.clr_all || (i_upd.free_one && (i_upd.idx == MY_IDX))
                        || (i_upd.clr_sess && w_sess_hit);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.active) begin
            if (w_match && !i_carry.hit) begin
                n_carry.hit        = 1'b1;
                n_carry.hit_idx    = MY_IDX;
                n_carry.hit_ident  = r_ident;
                n_carry.hit_handle = r_handle;
                n_carry.hit_len    = r_len;
            end
            if (!r_valid && !i_carry.free_found) begin
                n_carry.free_found = 1'b1;
                n_carry.free_idx   = MY_IDX;
            end
            if (!i_carry.min_seen || (r_seq < i_carry.min_seq)) begin
                n_carry.min_seen = 1'b1;
                n_carry.min_seq  = r_seq;
                n_carry.min_idx  = MY_IDX;
            end
            if (w_sess_hit) begin
                n_carry.sess_cnt = i_carry.sess_cnt + CNT_W'(1);
            end
            if (r_valid) begin
                n_carry.valid_cnt = i_carry.valid_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_valid <= 1'b0;
            r_seq   <= '0;
        end else begin
            r_carry <= n_carry;
            if (w_free) begin
                r_valid <= 1'b0;
                r_seq   <= '0;
            end else if (i_upd.wr && (i_upd.idx == MY_IDX)) begin
                r_valid <= 1'b1;
                r_seq   <= i_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.wr && (i_upd.idx == MY_IDX) && !w_free) begin
            r_sess   <= i_session;
            r_req    <= i_request;
            r_ident  <= i_identity;
            r_handle <= i_handle;
            r_len    <= i_len;
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

/* rtl/core/keyed_response_cache_top.sv */
// Channel  Direction  Transfer carries
// i_req    in         cmd, session_key, request_key, identity_digest, identity_len,
//                     payload_handle, payload_len, reader_capacity
// o_rsp    out        status, found_handle, found_len, cleared_count
//
// After a command's transfer, a probe walks the row of entry cells one cell a cycle;
// the last carry is registered, then the table is updated and the result registered
// once the output register is free. A new command is taken once the
// previous one has been applied, while its result still waits in the output register.
// A stalled result holds the next command in the update step until it is taken.
// Reset is synchronous and active low; it empties the table and the sequence counter.
`default_nettype none

module keyed_response_cache_top #(
    parameter int CAPACITY       = krc_pkg::DEF_CAPACITY,
    parameter int MAX_PAYLOAD    = krc_pkg::DEF_MAX_PAYLOAD,
    parameter int IDENTITY_BYTES = krc_pkg::DEF_IDENTITY_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    krc_req_if.sink    i_req,
    krc_rsp_if.source  o_rsp
);
    import krc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic        r_start;
    logic [2:0]  r_cmd;
    logic [63:0] r_session;
    logic [63:0] r_request;
    logic [63:0] r_identity;
    logic [7:0]  r_ilen;
    logic [31:0] r_handle;
    logic [15:0] r_plen;
    logic [15:0] r_rcap;
    logic [31:0] r_counter;
    t_carry      r_fin;

    logic        r_out_valid;
    logic [3:0]  r_status;
    logic [31:0] r_found_handle;
    logic [15:0] r_found_len;
    logic [6:0]  r_cleared;

    t_carry      w_carry [CAPACITY+1];
    t_upd        w_upd;
    logic        w_accept;
    logic        w_apply;
    logic [3:0]  w_status;
    logic        w_give;
    logic [6:0]  w_count;
    logic        w_id_ok;
    logic [31:0] w_next_seq;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_id_ok    = (r_ilen == 8'(IDENTITY_BYTES));
    assign w_next_seq = r_counter + 32'd1;

    always_comb begin
        w_carry[0]        = '0;
        w_carry[0].active = r_start;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        krc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_carry    (w_carry[g]),
            .o_carry    (w_carry[g+1]),
            .i_upd      (w_upd),
            .i_session  (r_session),
            .i_request  (r_request),
            .i_identity (r_identity),
            .i_handle   (r_handle),
            .i_len      (r_plen),
            .i_seq      (w_next_seq)
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) begin
                n_state = S_SCAN;
            end
            S_SCAN:  if (w_carry[CAPACITY].active) begin
                n_state = S_APPLY;
            end
            S_APPLY: if (!r_out_valid || o_rsp.ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_apply     = (r_state == S_APPLY) && (!r_out_valid || o_rsp.ready);
    end

    always_comb begin
        w_upd    = '0;
        w_status = ST_INVALID;
        w_give   = 1'b0;
        w_count  = '0;
        case (r_cmd)
            CMD_STORE: begin
                if ((r_session == '0) || (r_request == '0) || !w_id_ok) begin
                    w_status = ST_INVALID;
                end else if ((r_plen == '0) || (r_plen >= 16'(MAX_PAYLOAD))) begin
                    w_status = ST_TOO_LARGE;
                end else if (r_fin.hit) begin
                    w_status = (r_fin.hit_ident == r_identity) ? ST_DUPLICATE : ST_CONFLICT;
                end else begin
                    w_status = ST_STORED;
                    w_upd.wr = 1'b1;
                    w_upd.idx = r_fin.free_found ? r_fin.free_idx : r_fin.min_idx;
                end
            end
            CMD_RETRY: begin
                if (!w_id_ok || (r_rcap == '0)) begin
                    w_status = ST_INVALID;
                end else if (!r_fin.hit) begin
                    w_status = ST_NOT_FOUND;
                end else if (r_fin.hit_ident != r_identity) begin
                    w_status = ST_CONFLICT;
                end else if (r_fin.hit_len >= r_rcap) begin
                    w_status = ST_INVALID;
                end else begin
                    w_status = ST_MATCH;
                    w_give   = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (r_rcap == '0) begin
                    w_status = ST_FAILED;
                end else if (!r_fin.hit) begin
                    w_status = ST_NOT_FOUND;
                end else if (r_fin.hit_len >= r_rcap) begin
                    w_status = ST_FAILED;
                end else begin
                    w_status = ST_MATCH;
                    w_give   = 1'b1;
                end
            end
            CMD_ACK: begin
                if (!r_fin.hit) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_status       = ST_DONE;
                    w_count        = 7'd1;
                    w_upd.free_one = 1'b1;
                    w_upd.idx      = r_fin.hit_idx;
                end
            end
            CMD_CLR_SESS: begin
                w_status       = ST_DONE;
                w_count        = r_fin.sess_cnt;
                w_upd.clr_sess = 1'b1;
            end
            CMD_CLR_ALL: begin
                w_status      = ST_DONE;
                w_count       = r_fin.valid_cnt;
                w_upd.clr_all = 1'b1;
            end
            default: w_status = ST_INVALID;
        endcase
        if (!w_apply) begin
            w_upd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (w_upd.wr) begin
                r_counter <= w_next_seq;
            end
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_req.cmd;
            r_session  <= i_req.session_key;
            r_request  <= i_req.request_key;
            r_identity <= i_req.identity_digest;
            r_ilen     <= i_req.identity_len;
            r_handle   <= i_req.payload_handle;
            r_plen     <= i_req.payload_len;
            r_rcap     <= i_req.reader_capacity;
        end
        if (w_carry[CAPACITY].active) begin
            r_fin <= w_carry[CAPACITY];
        end
        if (w_apply) begin
            r_status       <= w_status;
            r_found_handle <= w_give ? r_fin.hit_handle : '0;
            r_found_len    <= w_give ? r_fin.hit_len : '0;
            r_cleared      <= w_count;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.found_handle  = r_found_handle;
    assign o_rsp.found_len     = r_found_len;
    assign o_rsp.cleared_count = r_cleared;

`ifndef NO_ASSERTIONS
    a_rise_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("result appeared outside the update step");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("second command taken while one is in flight");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_cleared <= 7'(CAPACITY)))
        else $error("cleared count exceeds the table size");
    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && w_give) |-> (r_fin.hit_len != '0))
        else $error("matched entry holds a zero length");
`endif

endmodule

`default_nettype wire
